// File: rtl/jpq_pkg.sv
package jpq_pkg;

  localparam int unsigned RESULT_LIMIT = 32;

  typedef enum logic [2:0] {
    CMD_ADD     = 3'd0,
    CMD_SCHED   = 3'd1,
    CMD_PEEK    = 3'd2,
    CMD_REPLACE = 3'd3,
    CMD_DUMP    = 3'd4
  } cmd_code_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef struct packed {
    logic [15:0] id;
    logic [15:0] pr;
  } entry_t;

  typedef enum logic [2:0] {
    OP_HOLD   = 3'd0,
    OP_INSERT = 3'd1,
    OP_SHIFT  = 3'd2,
    OP_REMOVE = 3'd3,
    OP_ROTATE = 3'd4
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    entry_t   key;
  } cell_ctl_t;

  typedef struct packed {
    logic ahead;
    logic found;
  } link_t;

endpackage

// File: rtl/jpq_cell.sv
module jpq_cell import jpq_pkg::*; (
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  logic      occ,
  input  logic      tail,
  input  entry_t    left_entry,
  input  link_t     left_link,
  input  entry_t    right_entry,
  input  entry_t    head_entry,
  output entry_t    entry,
  output link_t     link
);

  entry_t entry_next;
  logic   match;

  // The key belongs at or before this slot when this slot is empty or sorts after it.
  assign link.ahead = !occ || (entry.pr < ctl.key.pr) ||
                      ((entry.pr == ctl.key.pr) && (entry.id > ctl.key.id));
  assign match      = occ && (entry.id == ctl.key.id);
  assign link.found = left_link.found || match;

  always_comb begin
    entry_next = entry;
    unique case (ctl.op)
      OP_INSERT: begin
        if (link.ahead) begin
          entry_next = left_link.ahead ? left_entry : ctl.key;
        end
      end
      OP_SHIFT: begin
        entry_next = right_entry;
      end
      OP_REMOVE: begin
        if (link.found) begin
          entry_next = right_entry;
        end
      end
      OP_ROTATE: begin
        entry_next = tail ? head_entry : right_entry;
      end
      default: begin
        entry_next = entry;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

// File: rtl/job_priority_queue.sv
// Channel   Handshake          Fields
// command   start / busy       cmd, job_id, priority_req
// result    done (strobe)      status, job_id_res, priority_res, last
//
// Add, schedule and peek first capture the item, then act on the cell row.
// Replace captures the item; the row then removes the old entry and inserts the new one.
// Dump streams one result per cycle, at most RESULT_LIMIT of them, as the row rotates.
// Synchronous reset empties the queue; stored entries are not cleared.
// Each result shows for one cycle on done; the receiver cannot stall.
module job_priority_queue import jpq_pkg::*; #(
  parameter int unsigned CAPACITY = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  cmd,
  input  logic [15:0] job_id,
  input  logic [15:0] priority_req,
  output logic        done,
  output logic [1:0]  status,
  output logic [15:0] job_id_res,
  output logic [15:0] priority_res,
  output logic        last
);

  localparam int unsigned CW       = $clog2(CAPACITY + 1);
  localparam int unsigned DUMP_MAX = (CAPACITY < RESULT_LIMIT) ? CAPACITY : RESULT_LIMIT;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_EXEC  = 4'b0010,
    S_REINS = 4'b0100,
    S_DUMP  = 4'b1000
  } state_t;

  state_t          state;
  logic [CW-1:0]   count;
  logic [CW-1:0]   idx;
  logic [CW-1:0]   dump_n;
  logic [2:0]      cmd_q;
  entry_t          key_q;
  cell_ctl_t       ctl;
  entry_t          entries [CAPACITY];
  link_t           links   [CAPACITY];
  logic            full;
  logic            empty;
  logic            any_found;

  assign busy      = (state != S_IDLE);
  assign full      = (count == CW'(CAPACITY));
  assign empty     = (count == '0);
  assign any_found = links[CAPACITY-1].found;
  assign dump_n    = (count > CW'(DUMP_MAX)) ? CW'(DUMP_MAX) : count;

  always_comb begin
    ctl.key = key_q;
    ctl.op  = OP_HOLD;
    unique case (state)
      S_EXEC: begin
        if ((cmd_q == CMD_ADD) && !full) begin
          ctl.op = OP_INSERT;
        end else if ((cmd_q == CMD_SCHED) && !empty) begin
          ctl.op = OP_SHIFT;
        end else if ((cmd_q == CMD_REPLACE) && !empty && any_found) begin
          ctl.op = OP_REMOVE;
        end
      end
      S_REINS: ctl.op = OP_INSERT;
      S_DUMP:  ctl.op = OP_ROTATE;
      default: ctl.op = OP_HOLD;
    endcase
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    entry_t left_entry;
    link_t  left_link;
    entry_t right_entry;

    if (i == 0) begin : g_first
      assign left_entry = '0;
      assign left_link  = '0;
    end else begin : g_inner
      assign left_entry = entries[i-1];
      assign left_link  = links[i-1];
    end

    if (i == CAPACITY - 1) begin : g_end
      assign right_entry = entries[i];
    end else begin : g_mid
      assign right_entry = entries[i+1];
    end

    jpq_cell u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .occ         (count > CW'(i)),
      .tail        (count == CW'(i + 1)),
      .left_entry  (left_entry),
      .left_link   (left_link),
      .right_entry (right_entry),
      .head_entry  (entries[0]),
      .entry       (entries[i]),
      .link        (links[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            cmd_q  <= cmd;
            key_q  <= '{id: job_id, pr: priority_req};
            state  <= S_EXEC;
          end
        end
        S_EXEC: begin
          state        <= S_IDLE;
          last         <= 1'b1;
          job_id_res   <= '0;
          priority_res <= '0;
          unique case (cmd_q)
            CMD_ADD: begin
              done <= 1'b1;
              if (full) begin
                status <= ST_FULL;
              end else begin
                status       <= ST_OK;
                job_id_res   <= key_q.id;
                priority_res <= key_q.pr;
                count        <= count + 1'b1;
              end
            end
            CMD_SCHED, CMD_PEEK: begin
              done <= 1'b1;
              if (empty) begin
                status <= ST_EMPTY;
              end else begin
                status       <= ST_OK;
                job_id_res   <= entries[0].id;
                priority_res <= entries[0].pr;
                if (cmd_q == CMD_SCHED) begin
                  count <= count - 1'b1;
                end
              end
            end
            CMD_REPLACE: begin
              if (empty) begin
                done   <= 1'b1;
                status <= ST_EMPTY;
              end else if (!any_found) begin
                done   <= 1'b1;
                status <= ST_NOTFOUND;
              end else begin
                count <= count - 1'b1;
                state <= S_REINS;
              end
            end
            CMD_DUMP: begin
              if (empty) begin
                done   <= 1'b1;
                status <= ST_EMPTY;
              end else begin
                idx   <= '0;
                state <= S_DUMP;
              end
            end
            default: begin
              state <= S_IDLE;
            end
          endcase
        end
        S_REINS: begin
          done         <= 1'b1;
          status       <= ST_OK;
          job_id_res   <= key_q.id;
          priority_res <= key_q.pr;
          last         <= 1'b1;
          count        <= count + 1'b1;
          state        <= S_IDLE;
        end
        S_DUMP: begin
          if (idx < dump_n) begin
            done         <= 1'b1;
            status       <= ST_OK;
            job_id_res   <= entries[0].id;
            priority_res <= entries[0].pr;
            last         <= (idx == dump_n - 1'b1);
          end
          idx <= idx + 1'b1;
          if (idx == count - 1'b1) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("queue count exceeds capacity");

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result without a command in progress");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  a_dump_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_DUMP) |=> (count == $past(count)))
    else $error("queue count changed during dump");

  a_reins_room: assert property (@(posedge clk) disable iff (rst)
    (state == S_REINS) |-> (count < CW'(CAPACITY)))
    else $error("no room to reinsert replaced item");

  a_error_last: assert property (@(posedge clk) disable iff (rst)
    (done && (status != ST_OK)) |-> last)
    else $error("error result not marked last");
`endif

endmodule

// File: tb/job_priority_queue_tb.sv
`timescale 1ns / 1ps

module job_priority_queue_tb;
  import jpq_pkg::*;

  localparam int unsigned QUEUE_DEPTH = 32;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned DRAIN_CYCLES = 64;
  localparam int unsigned REPORT_MAX = 10;
  localparam logic [2:0] CMD_RSVD_5 = 3'd5;
  localparam logic [2:0] CMD_RSVD_6 = 3'd6;
  localparam logic [2:0] CMD_RSVD_7 = 3'd7;

  typedef struct {
    logic [2:0]  op;
    logic [15:0] id;
    logic [15:0] pr;
    int unsigned gap;
  } job_cmd_t;

  typedef struct {
    status_t     st;
    logic [15:0] id;
    logic [15:0] pr;
    logic        fin;
  } job_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  cmd = CMD_ADD;
  logic [15:0] job_id = '0;
  logic [15:0] priority_req = '0;
  logic        done;
  logic [1:0]  status;
  logic [15:0] job_id_res;
  logic [15:0] priority_res;
  logic        last;

  job_cmd_t    pending_cmds[$];
  job_result_t results_due[$];
  logic [15:0] known_ids[$];
  logic [15:0] sorted_ids[QUEUE_DEPTH];
  logic [15:0] sorted_prs[QUEUE_DEPTH];
  int unsigned job_count = 0;
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned hold_left = 0;
  logic        took = 1'b0;
  bit          calm = 1'b0;
  job_cmd_t    nxt_cmd;
  job_result_t got;

  job_priority_queue DUT (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .cmd          (cmd),
    .job_id       (job_id),
    .priority_req (priority_req),
    .done         (done),
    .status       (status),
    .job_id_res   (job_id_res),
    .priority_res (priority_res),
    .last         (last)
  );

  always #1 clk = ~clk;

  function automatic void push_due(status_t st, logic [15:0] id, logic [15:0] pr, logic fin);
    job_result_t r;
    r.st = st;
    r.id = id;
    r.pr = pr;
    r.fin = fin;
    results_due.push_back(r);
  endfunction

  function automatic void insert_job(logic [15:0] id, logic [15:0] pr);
    int unsigned pos;
    pos = 0;
    while (pos < job_count) begin
      if (sorted_prs[pos] < pr) break;
      if (sorted_prs[pos] == pr && sorted_ids[pos] > id) break;
      pos++;
    end
    for (int unsigned i = job_count; i > pos; i--) begin
      sorted_ids[i] = sorted_ids[i - 1];
      sorted_prs[i] = sorted_prs[i - 1];
    end
    sorted_ids[pos] = id;
    sorted_prs[pos] = pr;
    job_count++;
  endfunction

  function automatic void remove_job(int unsigned pos);
    for (int unsigned i = pos; i + 1 < job_count; i++) begin
      sorted_ids[i] = sorted_ids[i + 1];
      sorted_prs[i] = sorted_prs[i + 1];
    end
    job_count--;
  endfunction

  function automatic void apply_job_command(logic [2:0] op, logic [15:0] id, logic [15:0] pr);
    int unsigned pos;
    case (op)
      CMD_ADD: begin
        if (job_count >= QUEUE_DEPTH) begin
          push_due(ST_FULL, '0, '0, 1'b1);
        end else begin
          insert_job(id, pr);
          push_due(ST_OK, id, pr, 1'b1);
        end
      end
      CMD_SCHED, CMD_PEEK: begin
        if (job_count == 0) begin
          push_due(ST_EMPTY, '0, '0, 1'b1);
        end else begin
          push_due(ST_OK, sorted_ids[0], sorted_prs[0], 1'b1);
          if (op == CMD_SCHED) remove_job(0);
        end
      end
      CMD_REPLACE: begin
        if (job_count == 0) begin
          push_due(ST_EMPTY, '0, '0, 1'b1);
        end else begin
          pos = 0;
          while (pos < job_count && sorted_ids[pos] != id) pos++;
          if (pos == job_count) begin
            push_due(ST_NOTFOUND, '0, '0, 1'b1);
          end else begin
            remove_job(pos);
            insert_job(id, pr);
            push_due(ST_OK, id, pr, 1'b1);
          end
        end
      end
      CMD_DUMP: begin
        if (job_count == 0) begin
          push_due(ST_EMPTY, '0, '0, 1'b1);
        end else begin
          for (int unsigned i = 0; i < job_count && i < RESULT_LIMIT; i++)
            push_due(ST_OK, sorted_ids[i], sorted_prs[i],
                     (i + 1 == job_count || i + 1 == RESULT_LIMIT));
        end
      end
      default: begin
      end
    endcase
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (calm) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 65) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [15:0] pick_id();
    if (known_ids.size() != 0 && $urandom_range(0, 3) != 0)
      return known_ids[$urandom_range(0, known_ids.size() - 1)];
    if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
    return 16'($urandom_range(0, 16'hFFFF));
  endfunction

  function automatic logic [15:0] pick_priority();
    case ($urandom_range(0, 3))
      0, 1: return 16'($urandom_range(0, 3));
      2: return 16'($urandom_range(0, 16'hFFFF));
      default: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
    endcase
  endfunction

  function automatic void queue_cmd(logic [2:0] op, logic [15:0] id, logic [15:0] pr);
    job_cmd_t c;
    c.op = op;
    c.id = id;
    c.pr = pr;
    c.gap = pick_gap();
    pending_cmds.push_back(c);
    if (op == CMD_ADD) known_ids.push_back(id);
  endfunction

  function automatic void queue_random_cmd(int unsigned add_pct, int unsigned sched_pct);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < add_pct) begin
      queue_cmd(CMD_ADD, pick_id(), pick_priority());
    end else if (roll < add_pct + sched_pct) begin
      queue_cmd(CMD_SCHED, 16'($urandom), 16'($urandom));
    end else begin
      case ($urandom_range(0, 9))
        0, 1: queue_cmd(CMD_PEEK, 16'($urandom), 16'($urandom));
        2, 3, 4, 5: queue_cmd(CMD_REPLACE, pick_id(), pick_priority());
        6, 7: queue_cmd(CMD_DUMP, 16'($urandom), 16'($urandom));
        8: queue_cmd(CMD_RSVD_5 + 3'($urandom_range(0, 2)), 16'($urandom), 16'($urandom));
        default: queue_cmd(CMD_ADD, pick_id(), pick_priority());
      endcase
    end
  endfunction

  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!start || took) begin
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        start <= 1'b0;
      end else if (pending_cmds.size() != 0) begin
        nxt_cmd = pending_cmds.pop_front();
        start <= 1'b1;
        cmd <= nxt_cmd.op;
        job_id <= nxt_cmd.id;
        priority_req <= nxt_cmd.pr;
        hold_left <= nxt_cmd.gap;
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      took <= 1'b0;
    end else begin
      took <= start && !busy;
      if (start && !busy) apply_job_command(cmd, job_id, priority_req);
      if (done) begin
        if (results_due.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("Unexpected result: status=%0d id=%h pr=%h last=%b",
                     status, job_id_res, priority_res, last);
        end else begin
          got = results_due.pop_front();
          if (status !== got.st || job_id_res !== got.id || priority_res !== got.pr ||
              last !== got.fin) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
              $display({"Result mismatch: expected status=%0d id=%h pr=%h last=%b, ",
                        "got status=%0d id=%h pr=%h last=%b"},
                       got.st, got.id, got.pr, got.fin,
                       status, job_id_res, priority_res, last);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    // Empty queue, unused codes, field extremes, ties and duplicate ids.
    queue_cmd(CMD_SCHED, 16'h0000, 16'h0000);
    queue_cmd(CMD_PEEK, 16'hFFFF, 16'hFFFF);
    queue_cmd(CMD_DUMP, 16'h0000, 16'h0000);
    queue_cmd(CMD_REPLACE, 16'h0005, 16'h0009);
    queue_cmd(CMD_RSVD_5, 16'h1111, 16'h2222);
    queue_cmd(CMD_RSVD_6, 16'hFFFF, 16'hFFFF);
    queue_cmd(CMD_RSVD_7, 16'h0000, 16'h0000);
    queue_cmd(CMD_ADD, 16'h0000, 16'h0000);
    queue_cmd(CMD_ADD, 16'hFFFF, 16'hFFFF);
    queue_cmd(CMD_ADD, 16'h0007, 16'h0064);
    queue_cmd(CMD_ADD, 16'h0003, 16'h0064);
    queue_cmd(CMD_ADD, 16'h0007, 16'h0064);
    queue_cmd(CMD_PEEK, 16'h0000, 16'h0000);
    queue_cmd(CMD_REPLACE, 16'h0007, 16'hFFFF);
    queue_cmd(CMD_REPLACE, 16'h1234, 16'h0001);
    queue_cmd(CMD_DUMP, 16'h0000, 16'h0000);
    queue_cmd(CMD_SCHED, 16'h0000, 16'h0000);
    queue_cmd(CMD_ADD, 16'hAAAA, 16'h5555);
    queue_cmd(CMD_ADD, 16'h5555, 16'hAAAA);
    queue_cmd(CMD_DUMP, 16'h0000, 16'h0000);

    calm = 1'b0;
    repeat (6) queue_random_cmd(40, 15);
    // A run of adds fills the queue and then hits the full case.
    calm = 1'b1;
    repeat (36) queue_cmd(CMD_ADD, pick_id(), pick_priority());
    queue_cmd(CMD_DUMP, 16'($urandom), 16'($urandom));
    calm = 1'b0;
    queue_cmd(CMD_PEEK, 16'($urandom), 16'($urandom));
    repeat (4) queue_cmd(CMD_REPLACE, pick_id(), pick_priority());
    queue_cmd(CMD_DUMP, 16'($urandom), 16'($urandom));
    repeat (34) queue_cmd(CMD_SCHED, 16'($urandom), 16'($urandom));
    repeat (5) queue_random_cmd(35, 20);
    calm = 1'b1;
    repeat (3) queue_random_cmd(35, 20);

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending_cmds.size() != 0 || start) @(posedge clk);
    while (results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && results_due.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/jpq_pkg.sv
rtl/jpq_cell.sv
rtl/job_priority_queue.sv
tb/job_priority_queue_tb.sv
